>>> rtl/cbor_skip_pkg.sv
package cbor_skip_pkg;

   // Fixed widths of the stream fields.
   localparam int LEVEL_W = 5;
   localparam int ARG_W   = 64;

   // Result status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_OVERRUN  = 3'd1;
   localparam logic [2:0] ST_BAD_INFO = 3'd2;
   localparam logic [2:0] ST_NEG_OVF  = 3'd3;
   localparam logic [2:0] ST_TAG      = 3'd4;
   localparam logic [2:0] ST_DEEP     = 3'd5;

   // Operation applied to the nesting stack.
   typedef struct packed {
      logic             clear;
      logic             push;
      logic             finish;
      logic [ARG_W-1:0] push_count;
   } stack_ctrl_type;

   // Stack level now, and the level and top-level flag an element finish would give.
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] fin_level;
      logic               fin_done;
   } stack_stat_type;

endpackage

>>> rtl/cbor_stream_item_skipper_core.sv
// CBOR item skipper core.
// Bytes of an encoded buffer arrive one per request on the req_ channel
// (req_valid/req_ready), with req_buffer_end marking the last byte of a buffer.
// The block decodes each head, skips string payloads and tracks array and
// map nesting; one result at most per byte leaves on the rsp_ channel
// (rsp_valid/rsp_ready): a decoded head, a completed top-level item or an error.
// After an error, bytes up to the buffer end are consumed without results.
// A request is taken into an input register, worked on once the result register
// is free, and its result is registered. One request is accepted every cycle
// while the receiver does not stall; the rate is set by the combinational pass
// of head decode and stack pop between the two registers.
// csr_wr_en/csr_wr_data write the max_depth limit; the user must do so only while
// idle, as the block itself does not enforce it.
// Reset (synchronous, active high) empties the stack, returns to head decode,
// drops any held request and result, and sets max_depth to 16.
// When the receiver stalls, the result register holds; the input register then
// fills and req_ready falls until the result is taken.
module cbor_stream_item_skipper_core
   import cbor_skip_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_buffer_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_head_valid,
   output logic [2:0]         rsp_major_type,
   output logic [ARG_W-1:0]   rsp_argument,
   output logic [LEVEL_W-1:0] rsp_nest_depth,
   output logic               rsp_item_done,
   output logic [2:0]         rsp_status,
   input  logic               csr_wr_en,
   input  logic [4:0]         csr_wr_data
);

   localparam logic [1:0] PH_HEAD    = 2'd0;
   localparam logic [1:0] PH_ARG     = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_DISCARD = 2'd3;

   // Registers.
   logic               s1_valid_ff, s1_valid_in;
   logic [7:0]         s1_byte_ff;
   logic               s1_end_ff;
   logic [4:0]         max_depth_ff;
   logic [1:0]         phase_ff, phase_in;
   logic [ARG_W-1:0]   acc_ff, acc_in;
   logic [3:0]         arg_left_ff, arg_left_in;
   logic [2:0]         pend_ff, pend_in;
   logic [ARG_W-1:0]   pay_left_ff, pay_left_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hv_ff;
   logic [2:0]         rsp_mj_ff;
   logic [ARG_W-1:0]   rsp_arg_ff;
   logic [LEVEL_W-1:0] rsp_nd_ff;
   logic               rsp_done_ff;
   logic [2:0]         rsp_st_ff;

   // Working signals.
   logic               advance;
   logic               req_accept;
   logic [2:0]         b_mj;
   logic [4:0]         b_info;
   logic               hv, done, produce;
   logic [2:0]         mj, st;
   logic [ARG_W-1:0]   arg;
   logic [LEVEL_W-1:0] nd;
   logic               hd_fire;
   logic [2:0]         hd_mj;
   logic [ARG_W-1:0]   hd_arg;
   logic [ARG_W-1:0]   acc_shift;
   logic [ARG_W-1:0]   cnt;
   logic [ARG_W-1:0]   pay_dec;
   logic               fin_req, push_req, clr_req;
   logic [LEVEL_W-1:0] level_after;
   stack_ctrl_type     sctrl;
   stack_stat_type     sstat;

   // Handshake.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   assign b_mj      = s1_byte_ff[7:5];
   assign b_info    = s1_byte_ff[4:0];
   assign acc_shift = {acc_ff[ARG_W-9:0], s1_byte_ff};
   assign pay_dec   = pay_left_ff - ARG_W'(1);

   // Decode of the held byte and the next stream state.
   always_comb begin
      hv          = 1'b0;
      mj          = 3'd0;
      st          = ST_OK;
      arg         = '0;
      nd          = sstat.level;
      done        = 1'b0;
      produce     = 1'b0;
      hd_fire     = 1'b0;
      hd_mj       = 3'd0;
      hd_arg      = '0;
      cnt         = '0;
      fin_req     = 1'b0;
      push_req    = 1'b0;
      clr_req     = 1'b0;
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      arg_left_in = arg_left_ff;
      pend_in     = pend_ff;
      pay_left_in = pay_left_ff;

      case (phase_ff)
         PH_HEAD: begin
            mj = b_mj;
            if (b_mj == 3'd6) begin
               st = ST_TAG;
            end else if (b_mj == 3'd7 || b_info < 5'd24) begin
               hd_fire = 1'b1;
               hd_mj   = b_mj;
               hd_arg  = ARG_W'(b_info);
            end else if (b_info >= 5'd28) begin
               st = ST_BAD_INFO;
            end else begin
               pend_in     = b_mj;
               acc_in      = '0;
               arg_left_in = 4'b0001 << b_info[1:0];
               phase_in    = PH_ARG;
            end
         end
         PH_ARG: begin
            mj          = pend_ff;
            acc_in      = acc_shift;
            arg_left_in = arg_left_ff - 4'd1;
            if (arg_left_in == 4'd0) begin
               hd_fire = 1'b1;
               hd_mj   = pend_ff;
               hd_arg  = acc_shift;
            end
         end
         PH_PAYLOAD: begin
            pay_left_in = pay_dec;
            if (pay_dec == '0) begin
               phase_in = PH_HEAD;
               fin_req  = 1'b1;
               nd       = sstat.fin_level;
            end else begin
               mj = pend_ff;
            end
         end
         default: begin
            clr_req = s1_end_ff;
         end
      endcase

      // Action on a completed head.
      if (hd_fire) begin
         hv       = 1'b1;
         arg      = hd_arg;
         phase_in = PH_HEAD;
         case (hd_mj)
            3'd1: begin
               if (hd_arg[ARG_W-1]) begin
                  st = ST_NEG_OVF;
               end else begin
                  fin_req = 1'b1;
               end
            end
            3'd2, 3'd3: begin
               if (hd_arg == '0) begin
                  fin_req = 1'b1;
               end else begin
                  pend_in     = hd_mj;
                  pay_left_in = hd_arg;
                  phase_in    = PH_PAYLOAD;
               end
            end
            3'd4, 3'd5: begin
               if (hd_mj == 3'd5) begin
                  cnt = hd_arg[ARG_W-1] ? '1 : {hd_arg[ARG_W-2:0], 1'b0};
               end else begin
                  cnt = hd_arg;
               end
               if (cnt == '0) begin
                  fin_req = 1'b1;
               end else if (sstat.level >= max_depth_ff
                            || int'(sstat.level) >= STACK_DEPTH) begin
                  st = ST_DEEP;
               end else begin
                  push_req = 1'b1;
               end
            end
            default: begin
               fin_req = 1'b1;
            end
         endcase
      end

      if (fin_req) begin
         done = sstat.fin_done;
      end

      // Level once this byte's stack operation is applied.
      if (push_req) begin
         level_after = sstat.level + LEVEL_W'(1);
      end else if (fin_req) begin
         level_after = sstat.fin_level;
      end else begin
         level_after = sstat.level;
      end

      // Errors and buffer end; discarded bytes give no result.
      if (phase_ff != PH_DISCARD) begin
         if (st == ST_OK && s1_end_ff && (phase_in != PH_HEAD || level_after != '0)) begin
            st = ST_OVERRUN;
         end
         if (st != ST_OK) begin
            done = 1'b0;
            if (s1_end_ff) begin
               clr_req = 1'b1;
            end else begin
               phase_in = PH_DISCARD;
            end
         end
         produce = hv || done || (st != ST_OK);
      end

      // Return to the reset stream state.
      if (clr_req) begin
         phase_in    = PH_HEAD;
         acc_in      = '0;
         arg_left_in = 4'd0;
         pend_in     = 3'd0;
         pay_left_in = '0;
      end
   end

   // Stack operation, applied only when the held byte moves on.
   always_comb begin
      sctrl.clear      = advance && clr_req;
      sctrl.push       = advance && push_req;
      sctrl.finish     = advance && fin_req;
      sctrl.push_count = cnt;
   end

   cbor_skip_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .ctrl  (sctrl),
      .stat  (sstat)
   );

   // Control next values.
   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (advance && produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers and stream state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_depth_ff <= 5'd16;
         phase_ff     <= PH_HEAD;
         acc_ff       <= '0;
         arg_left_ff  <= 4'd0;
         pend_ff      <= 3'd0;
         pay_left_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_depth_ff <= csr_wr_data;
         end
         if (advance) begin
            phase_ff    <= phase_in;
            acc_ff      <= acc_in;
            arg_left_ff <= arg_left_in;
            pend_ff     <= pend_in;
            pay_left_ff <= pay_left_in;
         end
      end
   end

   // Input and result payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_data_byte;
         s1_end_ff  <= req_buffer_end;
      end
      if (advance && produce) begin
         rsp_hv_ff   <= hv;
         rsp_mj_ff   <= mj;
         rsp_arg_ff  <= arg;
         rsp_nd_ff   <= nd;
         rsp_done_ff <= done;
         rsp_st_ff   <= st;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_head_valid = rsp_hv_ff;
   assign rsp_major_type = rsp_mj_ff;
   assign rsp_argument   = rsp_arg_ff;
   assign rsp_nest_depth = rsp_nd_ff;
   assign rsp_item_done  = rsp_done_ff;
   assign rsp_status     = rsp_st_ff;

   // A waiting result is not overwritten.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_arg_ff)))
      else $error("waiting result changed");

   // A completed item never comes with an error status.
   a_done_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_st_ff == ST_OK))
      else $error("item done together with an error");

   // A buffer end with an error leaves the stream in head decode.
   a_end_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_end_ff && st != ST_OK) |=> (phase_ff == PH_HEAD))
      else $error("stream not reset at buffer end");

endmodule

>>> rtl/cbor_skip_stack.sv
module cbor_skip_stack
   import cbor_skip_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  stack_ctrl_type ctrl,
   output stack_stat_type stat
);

   localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [ARG_W-1:0]   cnt_ff [STACK_DEPTH];
   logic               one_ff [STACK_DEPTH];
   logic [LEVEL_W-1:0] level_ff;
   logic [LEVEL_W-1:0] level_in;

   logic               found;
   logic [IW-1:0]      top_idx;
   logic [ARG_W-1:0]   top_cnt;
   logic [LEVEL_W-1:0] fin_level;

   // Find the innermost open container whose count does not run out with this element.
   always_comb begin
      found   = 1'b0;
      top_idx = '0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
         if ((int'(level_ff) > i) && !one_ff[i]) begin
            found   = 1'b1;
            top_idx = IW'(i);
         end
      end
   end

   assign top_cnt   = cnt_ff[top_idx];
   assign fin_level = found ? LEVEL_W'(int'(top_idx) + 1) : '0;

   assign stat.level     = level_ff;
   assign stat.fin_level = fin_level;
   assign stat.fin_done  = !found;

   // Next stack level.
   always_comb begin
      level_in = level_ff;
      if (ctrl.clear) begin
         level_in = '0;
      end else if (ctrl.push) begin
         level_in = level_ff + LEVEL_W'(1);
      end else if (ctrl.finish) begin
         level_in = fin_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   // Count storage: written on a push, decremented at the surviving level on a finish.
   always_ff @(posedge clock) begin
      if (!ctrl.clear && ctrl.push) begin
         cnt_ff[IW'(level_ff)] <= ctrl.push_count;
         one_ff[IW'(level_ff)] <= (ctrl.push_count == ARG_W'(1));
      end else if (!ctrl.clear && ctrl.finish && found) begin
         cnt_ff[top_idx] <= top_cnt - ARG_W'(1);
         one_ff[top_idx] <= (top_cnt == ARG_W'(2));
      end
   end

   // The level never passes the stack size.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      int'(level_ff) <= STACK_DEPTH)
      else $error("stack level beyond stack size");

   // A clear empties the stack.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> (level_ff == '0))
      else $error("stack not empty after clear");

   // A push opens exactly one level.
   a_push: assert property (@(posedge clock) disable iff (reset)
      (ctrl.push && !ctrl.clear) |=> (level_ff == $past(level_ff) + LEVEL_W'(1)))
      else $error("push did not open one level");

   // A finish lands on the level that was announced.
   a_finish: assert property (@(posedge clock) disable iff (reset)
      (ctrl.finish && !ctrl.clear && !ctrl.push) |=> (level_ff == $past(fin_level)))
      else $error("finish landed on wrong level");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import cbor_skip_pkg::*;

   localparam int STACK_DEPTH   = 16;
   localparam int IDX_W         = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 200000;

   // CBOR major types.
   localparam logic [2:0] MT_UINT   = 3'd0;
   localparam logic [2:0] MT_NINT   = 3'd1;
   localparam logic [2:0] MT_BSTR   = 3'd2;
   localparam logic [2:0] MT_TSTR   = 3'd3;
   localparam logic [2:0] MT_ARRAY  = 3'd4;
   localparam logic [2:0] MT_MAP    = 3'd5;
   localparam logic [2:0] MT_TAG    = 3'd6;
   localparam logic [2:0] MT_SIMPLE = 3'd7;

   // Additional info codes that announce argument bytes, and the first reserved one.
   localparam logic [4:0] AI_ARG1     = 5'd24;
   localparam logic [4:0] AI_ARG2     = 5'd25;
   localparam logic [4:0] AI_ARG4     = 5'd26;
   localparam logic [4:0] AI_ARG8     = 5'd27;
   localparam logic [4:0] AI_RESERVED = 5'd28;

   typedef enum logic [1:0] {
      PH_HEAD,
      PH_ARG,
      PH_PAYLOAD,
      PH_DISCARD
   } scan_phase_type;

   typedef struct packed {
      logic               head_valid;
      logic [2:0]         major_type;
      logic [ARG_W-1:0]   argument;
      logic [LEVEL_W-1:0] nest_depth;
      logic               item_done;
      logic [2:0]         status;
   } skip_report_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   logic [7:0]         req_data_byte  = 8'd0;
   logic               req_buffer_end = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   logic               rsp_head_valid;
   logic [2:0]         rsp_major_type;
   logic [ARG_W-1:0]   rsp_argument;
   logic [LEVEL_W-1:0] rsp_nest_depth;
   logic               rsp_item_done;
   logic [2:0]         rsp_status;
   logic               csr_wr_en      = 1'b0;
   logic [4:0]         csr_wr_data    = 5'd0;

   // Decoder state mirrored by the predictor.
   scan_phase_type     scan_phase;
   logic [63:0]        arg_acc;
   logic [3:0]         arg_left;
   logic [2:0]         held_major;
   logic [63:0]        skip_left;
   logic [63:0]        open_count [STACK_DEPTH];
   logic [LEVEL_W-1:0] open_level;
   logic [4:0]         depth_limit;

   skip_report_type    expected_reports [$];
   logic [7:0]         frame_q [$];
   int                 node_budget;
   int                 send_idle_pct   = 0;
   int                 recv_stall_pct  = 0;
   int unsigned        bytes_sent      = 0;
   int unsigned        results_checked = 0;
   int unsigned        error_count     = 0;
   int unsigned        cycle_count     = 0;

   cbor_stream_item_skipper_core #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_buffer_end(req_buffer_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_head_valid(rsp_head_valid),
      .rsp_major_type(rsp_major_type),
      .rsp_argument  (rsp_argument),
      .rsp_nest_depth(rsp_nest_depth),
      .rsp_item_done (rsp_item_done),
      .rsp_status    (rsp_status),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_reports.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The receiver stalls at random, at the rate the current phase sets.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // Back to the start of a stream; the depth limit is kept.
   function automatic void clear_scan();
      scan_phase = PH_HEAD;
      arg_acc    = '0;
      arg_left   = '0;
      held_major = '0;
      skip_left  = '0;
      open_level = '0;
      for (int i = 0; i < STACK_DEPTH; i++) open_count[i] = '0;
   endfunction

   // One element has finished: pop every container it completes. True at top level.
   function automatic logic close_element();
      logic [IDX_W-1:0] t;
      while (open_level > 0 && open_level <= STACK_DEPTH) begin
         t = IDX_W'(open_level - LEVEL_W'(1));
         open_count[t] = open_count[t] - 64'd1;
         if (open_count[t] != 0) return 1'b0;
         open_level = open_level - LEVEL_W'(1);
      end
      return 1'b1;
   endfunction

   // Act on a fully decoded head.
   function automatic void head_complete(input logic [2:0] mj, input logic [63:0] arg,
                                         output logic [2:0] st, output logic done);
      logic [63:0] cnt;
      int          lim;
      st         = ST_OK;
      done       = 1'b0;
      scan_phase = PH_HEAD;
      case (mj)
         MT_NINT: begin
            if (arg[63]) st = ST_NEG_OVF;
            else done = close_element();
         end
         MT_BSTR, MT_TSTR: begin
            if (arg == 0) begin
               done = close_element();
            end else begin
               held_major = mj;
               skip_left  = arg;
               scan_phase = PH_PAYLOAD;
            end
         end
         MT_ARRAY, MT_MAP: begin
            cnt = arg;
            // Map counts are doubled, saturating at all ones.
            if (mj == MT_MAP) cnt = arg[63] ? '1 : (arg << 1);
            if (cnt == 0) begin
               done = close_element();
            end else begin
               lim = (depth_limit < STACK_DEPTH) ? depth_limit : STACK_DEPTH;
               if (open_level >= lim) begin
                  st = ST_DEEP;
               end else begin
                  open_count[IDX_W'(open_level)] = cnt;
                  open_level = open_level + LEVEL_W'(1);
               end
            end
         end
         default: done = close_element();
      endcase
   endfunction

   // Work out the result, if any, that one accepted request causes.
   task automatic decode_step(input logic [7:0] b, input logic last);
      skip_report_type r;
      logic [4:0]      info;
      logic [2:0]      st;
      logic            done;
      logic            hv;
      r            = '0;
      st           = ST_OK;
      done         = 1'b0;
      hv           = 1'b0;
      r.nest_depth = open_level;
      case (scan_phase)
         PH_HEAD: begin
            r.major_type = b[7:5];
            info         = b[4:0];
            if (r.major_type == MT_TAG) begin
               st = ST_TAG;
            end else if (r.major_type == MT_SIMPLE || info < AI_ARG1) begin
               hv         = 1'b1;
               r.argument = {59'd0, info};
               head_complete(r.major_type, r.argument, st, done);
            end else if (info >= AI_RESERVED) begin
               st = ST_BAD_INFO;
            end else begin
               held_major = r.major_type;
               arg_acc    = '0;
               arg_left   = 4'd1 << (info - AI_ARG1);
               scan_phase = PH_ARG;
            end
         end
         PH_ARG: begin
            r.major_type = held_major;
            arg_acc      = {arg_acc[55:0], b};
            arg_left     = arg_left - 4'd1;
            if (arg_left == 0) begin
               hv         = 1'b1;
               r.argument = arg_acc;
               head_complete(r.major_type, r.argument, st, done);
            end
         end
         PH_PAYLOAD: begin
            skip_left = skip_left - 64'd1;
            if (skip_left == 0) begin
               // A finished payload reports with major type zero.
               scan_phase   = PH_HEAD;
               done         = close_element();
               r.nest_depth = open_level;
            end else begin
               r.major_type = held_major;
            end
         end
         default: begin
            if (last) clear_scan();
            return;
         end
      endcase

      // The buffer ending on anything unfinished is an overrun.
      if (st == ST_OK && last && (scan_phase != PH_HEAD || open_level != 0)) st = ST_OVERRUN;
      if (st != ST_OK) begin
         done = 1'b0;
         if (last) clear_scan();
         else scan_phase = PH_DISCARD;
      end

      if (hv || done || st != ST_OK) begin
         r.head_valid = hv;
         r.item_done  = done;
         r.status     = st;
         expected_reports.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin : check_results
      skip_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $error("Result with no expected entry: status %0d, major %0d.",
                   rsp_status, rsp_major_type);
            error_count++;
         end else begin
            want = expected_reports.pop_front();
            results_checked++;
            if (rsp_head_valid !== want.head_valid) begin
               $error("rsp_head_valid: expected %0d, got %0d", want.head_valid, rsp_head_valid);
               error_count++;
            end
            if (rsp_major_type !== want.major_type) begin
               $error("rsp_major_type: expected %0d, got %0d", want.major_type, rsp_major_type);
               error_count++;
            end
            if (rsp_argument !== want.argument) begin
               $error("rsp_argument: expected %h, got %h", want.argument, rsp_argument);
               error_count++;
            end
            if (rsp_nest_depth !== want.nest_depth) begin
               $error("rsp_nest_depth: expected %0d, got %0d", want.nest_depth, rsp_nest_depth);
               error_count++;
            end
            if (rsp_item_done !== want.item_done) begin
               $error("rsp_item_done: expected %0d, got %0d", want.item_done, rsp_item_done);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------------

   // Send one request and hold it until accepted, then idle at the phase's rate.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_buffer_end <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_step(b, last);
      bytes_sent++;
      gap = 0;
      while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Send the assembled buffer, marking its last byte.
   task automatic send_frame();
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   // Stop sending until every expected result has come, then let the pipeline settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the nesting limit; only called with the block idle.
   task automatic set_max_depth(input logic [4:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      depth_limit = value;
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------------------

   function automatic logic [63:0] rand_arg();
      case ($urandom_range(0, 5))
         0:       return 64'($urandom_range(0, 23));
         1:       return 64'($urandom_range(0, 255));
         2:       return 64'($urandom_range(0, 65535));
         3:       return {32'd0, $urandom};
         4:       return {$urandom, $urandom};
         default: return '1;
      endcase
   endfunction

   // Encode a head, sometimes with a wider argument than needed.
   task automatic put_head(input logic [2:0] mj, input logic [63:0] arg);
      int         nb;
      logic [4:0] info;
      if (arg < 24 && $urandom_range(0, 3) != 0) begin
         frame_q.push_back({mj, arg[4:0]});
         return;
      end
      if (arg < 64'h100) nb = 1;
      else if (arg < 64'h1_0000) nb = 2;
      else if (arg < 64'h1_0000_0000) nb = 4;
      else nb = 8;
      if (nb < 8 && $urandom_range(0, 5) == 0) nb = nb * 2;
      case (nb)
         1:       info = AI_ARG1;
         2:       info = AI_ARG2;
         4:       info = AI_ARG4;
         default: info = AI_ARG8;
      endcase
      frame_q.push_back({mj, info});
      for (int i = nb - 1; i >= 0; i--) frame_q.push_back(arg[8*i +: 8]);
   endtask

   // Append one well-formed item with random content; each item uses up budget, and containers need budget left.
   task automatic build_item(input int lvl);
      int          kind;
      int          n;
      logic [63:0] a;
      kind = $urandom_range(0, 9);
      if (kind >= 6 && (node_budget == 0 || lvl >= 6)) kind = 0;
      if (node_budget > 0) node_budget--;
      case (kind)
         0, 1: put_head(MT_UINT, rand_arg());
         2: begin
            a = rand_arg();
            // Mostly in range; the rest may overflow.
            if ($urandom_range(0, 15) != 0) a[63] = 1'b0;
            put_head(MT_NINT, a);
         end
         3, 4: begin
            n = $urandom_range(0, 6);
            put_head((kind == 3) ? MT_BSTR : MT_TSTR, 64'(n));
            repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
         end
         5: frame_q.push_back({MT_SIMPLE, 5'($urandom_range(0, 31))});
         6, 7: begin
            n = $urandom_range(0, 3);
            put_head(MT_ARRAY, 64'(n));
            repeat (n) build_item(lvl + 1);
         end
         default: begin
            n = $urandom_range(0, 2);
            put_head(MT_MAP, 64'(n));
            repeat (2 * n) build_item(lvl + 1);
         end
      endcase
   endtask

   // Mostly well-formed buffers, some deep, some truncated or corrupted, some noise.
   task automatic build_frame();
      int mode;
      int keep;
      frame_q.delete();
      mode = $urandom_range(0, 19);
      if (mode < 3) begin
         repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      if (mode == 3) begin
         repeat ($urandom_range(1, STACK_DEPTH + 1)) frame_q.push_back({MT_ARRAY, 5'd1});
      end
      repeat ($urandom_range(1, 3)) begin
         node_budget = $urandom_range(1, 12);
         build_item(0);
      end
      if (mode < 6) begin
         keep = $urandom_range(1, frame_q.size());
         while (frame_q.size() > keep) void'(frame_q.pop_back());
      end else if (mode == 6) begin
         frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Field extremes, every major type and the error and discard behaviour.
   task automatic test_directed_heads();
      frame_q = '{8'h00};
      send_frame();
      // Simple values take one byte whatever the info.
      frame_q = '{{MT_SIMPLE, AI_ARG1}};
      send_frame();
      frame_q = '{8'hFF};
      send_frame();
      // A tag is rejected.
      frame_q = '{{MT_TAG, 5'd0}};
      send_frame();
      frame_q = '{{MT_UINT, AI_RESERVED}};
      send_frame();
      // Negative integer argument of 2^63.
      frame_q = '{{MT_NINT, AI_ARG8}, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_frame();
      // Text string payload is skipped.
      frame_q = '{{MT_TSTR, 5'd2}, 8'h61, 8'h62};
      send_frame();
      // Map of one pair with an empty byte string value.
      frame_q = '{{MT_MAP, 5'd1}, 8'h01, {MT_BSTR, 5'd0}};
      send_frame();
      // Buffer ends inside an open array.
      frame_q = '{{MT_ARRAY, 5'd2}, 8'h01};
      send_frame();
      // After an error the rest of the buffer is dropped.
      frame_q = '{{MT_TAG, 5'd0}, 8'h00, 8'h01};
      send_frame();
      drain_results();
   endtask

   // Nesting limit at both extremes, and a map count that saturates when doubled.
   task automatic test_nesting_limits();
      set_max_depth(5'd1);
      frame_q = '{{MT_ARRAY, 5'd1}, {MT_ARRAY, 5'd1}, 8'h00};
      send_frame();
      frame_q = '{{MT_ARRAY, 5'd2}, 8'h00, {MT_MAP, 5'd0}};
      send_frame();
      drain_results();
      set_max_depth(5'd16);
      for (int d = STACK_DEPTH; d <= STACK_DEPTH + 1; d++) begin
         frame_q.delete();
         repeat (d) frame_q.push_back({MT_ARRAY, 5'd1});
         frame_q.push_back(8'h00);
         send_frame();
      end
      frame_q = '{{MT_MAP, AI_ARG8}, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_frame();
      drain_results();
   endtask

   // Random buffers under one idle and stall mix, with the odd pause until all results are in.
   task automatic test_random_traffic(input int n_bytes, input int idle_pct,
                                      input int stall_pct);
      int unsigned start;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start          = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         build_frame();
         send_frame();
         if ($urandom_range(0, 29) == 0) drain_results();
      end
      drain_results();
   endtask

   initial begin
      clear_scan();
      depth_limit = 5'd16;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_heads();
      test_nesting_limits();

      set_max_depth(5'd16);
      test_random_traffic(250, 0, 0);
      set_max_depth(5'($urandom_range(2, 15)));
      test_random_traffic(250, 74, 0);
      set_max_depth(5'd1);
      test_random_traffic(250, 0, 74);
      set_max_depth(5'd16);
      test_random_traffic(250, 12, 12);

      $display("Sent %0d request bytes and checked %0d results across nesting limits",
               bytes_sent, results_checked);
      $display("from 1 to 16, under free-running, idle-sender and stalled-receiver mixes.");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
